[hw/rtl/qsmc_pkg.sv]
// Package for the queue simulation block: widths, register map and config struct.
// No dependencies; imported by every module of the block.
package qsmc_pkg;

  // Sizing of the simulated queue and of the mean's fraction
  localparam int QUEUE_BITS    = 20;
  localparam int FRACTION_BITS = 12;

  // Field and state widths
  localparam int SMP_W    = 16;
  localparam int QLEN_W   = 20;
  localparam int SUM_W    = 44;
  localparam int STEP_W   = 24;
  localparam int STABLE_W = 16;
  localparam int MEAN_W   = 32;
  localparam int TOL_W    = 24;
  localparam int PROD_W   = MEAN_W + TOL_W;
  localparam int DIVD_W   = SUM_W + FRACTION_BITS;

  // APB port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Register indexes (byte address / 4)
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ZERO_LIM = 3'd0;
  localparam reg_idx_t REG_ONE_LIM  = 3'd1;
  localparam reg_idx_t REG_HALF_TOL = 3'd2;
  localparam reg_idx_t REG_STABLE   = 3'd3;
  localparam reg_idx_t REG_STEP_LIM = 3'd4;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [SMP_W-1:0]    zero_lim;
    logic [SMP_W-1:0]    one_lim;
    logic [TOL_W-1:0]    half_tol;
    logic [STABLE_W-1:0] stable_needed;
    logic [STEP_W-1:0]   step_limit;
  } cfg_t;

endpackage

[hw/rtl/qsmc_cfg.sv]
// APB configuration registers of the queue simulation block.
// Depends on qsmc_pkg.
module qsmc_cfg
  import qsmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_lim      <= SMP_W'(32768);
      cfg_q.one_lim       <= SMP_W'(65535);
      cfg_q.half_tol      <= TOL_W'(8389);
      cfg_q.stable_needed <= STABLE_W'(1000);
      cfg_q.step_limit    <= STEP_W'(1000000);
    end else if (wr_en) begin
      case (idx)
        REG_ZERO_LIM: cfg_q.zero_lim      <= pwdata[SMP_W-1:0];
        REG_ONE_LIM:  cfg_q.one_lim       <= pwdata[SMP_W-1:0];
        REG_HALF_TOL: cfg_q.half_tol      <= pwdata[TOL_W-1:0];
        REG_STABLE:   cfg_q.stable_needed <= pwdata[STABLE_W-1:0];
        REG_STEP_LIM: cfg_q.step_limit    <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_ZERO_LIM: prdata = APB_DW'(cfg_q.zero_lim);
      REG_ONE_LIM:  prdata = APB_DW'(cfg_q.one_lim);
      REG_HALF_TOL: prdata = APB_DW'(cfg_q.half_tol);
      REG_STABLE:   prdata = APB_DW'(cfg_q.stable_needed);
      REG_STEP_LIM: prdata = APB_DW'(cfg_q.step_limit);
      default:      prdata = '0;
    endcase
  end

endmodule

[hw/rtl/qsmc_mul.sv]
// Bit-serial shift-add multiplier: mean reference times half tolerance.
// Depends on qsmc_pkg; one multiplier bit per cycle.
module qsmc_mul
  import qsmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MEAN_W-1:0] a_i,
  input  logic [TOL_W-1:0]  b_i,
  output logic [PROD_W-1:0] product_o,
  output logic              busy_o
);

  localparam int CNT_W = $clog2(TOL_W);

  logic [PROD_W-1:0] acc_q, mcand_q;
  logic [TOL_W-1:0]  mplier_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;

  assign product_o = acc_q;
  assign busy_o    = busy_q;

  // One partial product per cycle, LSB of the multiplier first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      cnt_q    <= '0;
      acc_q    <= '0;
      mcand_q  <= PROD_W'(a_i);
      mplier_q <= b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[TOL_W-1:1]};
      cnt_q    <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(TOL_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/qsmc_div.sv]
// Restoring bit-serial divider for the running mean, saturating at MEAN_W bits.
// Depends on qsmc_pkg; one quotient bit per cycle.
module qsmc_div
  import qsmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [STEP_W-1:0] divisor_i,
  output logic [MEAN_W-1:0] quotient_o,
  output logic              busy_o
);

  localparam int CNT_W = $clog2(MEAN_W);
  localparam int TOP_W = DIVD_W - MEAN_W;
  localparam int CMP_W = (TOP_W > STEP_W) ? TOP_W : STEP_W;

  logic [STEP_W-1:0] rem_q, div_q;
  logic [MEAN_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, sat_q;
  logic [TOP_W-1:0]  top;
  logic [STEP_W:0]   trial;
  logic              ge;

  assign top        = dividend_i[DIVD_W-1:MEAN_W];
  assign trial      = {rem_q, quo_q[MEAN_W-1]};
  assign ge         = trial >= {1'b0, div_q};
  assign quotient_o = sat_q ? '1 : quo_q;
  assign busy_o     = busy_q;

  // Upper dividend part preloads the remainder; a quotient that cannot fit
  // is caught up front and forced to all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      sat_q  <= CMP_W'(top) >= CMP_W'(divisor_i);
      cnt_q  <= '0;
      rem_q  <= STEP_W'(top);
      div_q  <= divisor_i;
      quo_q  <= dividend_i[MEAN_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? STEP_W'(trial - {1'b0, div_q}) : trial[STEP_W-1:0];
      quo_q <= {quo_q[MEAN_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MEAN_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/queue_sim_mean_convergence_top.sv]
// Top level of the queue simulation block: step sequencer, run state, output register.
// Depends on qsmc_pkg, qsmc_cfg, qsmc_mul, qsmc_div.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o     | random_sample_i, restart_i
//  out     | out_valid_o / out_stall_i   | queue_length_o, mean_q12_o, steps_done_o,
//          |                             | converged_o, run_over_o
//  cfg     | APB psel/penable/pwrite     | paddr, pwdata, prdata
//
// A step runs S_LOAD, S_INIT, S_DIV, S_MEAN, S_UPD and S_OUT; S_DIV waits for the serial
// divider (one quotient bit per cycle) and for the tolerance product, which is formed
// bit-serially alongside it. Once the run is over a request goes from S_LOAD to S_OUT.
// Reset restores the register defaults and clears the run. The result sits in an
// output register, so the next request is taken while a result is still stalled.
module queue_sim_mean_convergence_top
  import qsmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SMP_W-1:0]  random_sample_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [QLEN_W-1:0] queue_length_o,
  output logic [MEAN_W-1:0] mean_q12_o,
  output logic [STEP_W-1:0] steps_done_o,
  output logic              converged_o,
  output logic              run_over_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_INIT, S_DIV, S_MEAN, S_UPD, S_OUT
  } state_e;

  state_e state_q;
  cfg_t   cfg;

  // Run state
  logic [QUEUE_BITS-1:0] queue_q;
  logic [SUM_W-1:0]      sum_q;
  logic [STEP_W-1:0]     step_q;
  logic [STABLE_W-1:0]   stable_q;
  logic [MEAN_W-1:0]     ref_q, last_mean_q, diff_q;
  logic                  done_q, conv_q;
  logic [SMP_W-1:0]      sample_q;

  // Output register
  logic                  out_valid_q;
  logic [QLEN_W-1:0]     qlen_oq;
  logic [MEAN_W-1:0]     mean_oq;
  logic [STEP_W-1:0]     steps_oq;
  logic                  conv_oq, over_oq;

  // Step datapath
  logic [1:0]            arrivals;
  logic [QUEUE_BITS:0]   q_sum;
  logic [QUEUE_BITS-1:0] q_sat, q_next;
  logic [SUM_W:0]        sum_wide;
  logic [SUM_W-1:0]      sum_next;
  logic [STEP_W-1:0]     step_next;
  logic [MEAN_W-1:0]     mean, diff;
  logic                  in_band;
  logic [STABLE_W-1:0]   stable_next;
  logic                  conv_next;

  // Serial units
  logic                  unit_start, mul_busy, div_busy;
  logic [PROD_W-1:0]     band_prod;

  qsmc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  assign unit_start = (state_q == S_INIT);

  qsmc_mul u_mul (
    .clk_i, .rst_ni,
    .start_i   (unit_start),
    .a_i       (ref_q),
    .b_i       (cfg.half_tol),
    .product_o (band_prod),
    .busy_o    (mul_busy)
  );

  qsmc_div u_div (
    .clk_i, .rst_ni,
    .start_i    (unit_start),
    .dividend_i ({sum_q, {FRACTION_BITS{1'b0}}}),
    .divisor_i  (step_q),
    .quotient_o (mean),
    .busy_o     (div_busy)
  );

  // Arrivals, queue update, sum and step count
  always_comb begin
    if (sample_q < cfg.zero_lim)     arrivals = 2'd0;
    else if (sample_q < cfg.one_lim) arrivals = 2'd1;
    else                             arrivals = 2'd2;
    q_sum     = {1'b0, queue_q} + (QUEUE_BITS+1)'(arrivals);
    q_sat     = q_sum[QUEUE_BITS] ? '1 : q_sum[QUEUE_BITS-1:0];
    q_next    = (q_sat != '0) ? q_sat - QUEUE_BITS'(1) : q_sat;
    sum_wide  = {1'b0, sum_q} + (SUM_W+1)'(q_next);
    sum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    step_next = (step_q != '1) ? step_q + STEP_W'(1) : step_q;
  end

  // Band test and convergence
  always_comb begin
    diff        = (mean >= ref_q) ? mean - ref_q : ref_q - mean;
    in_band     = {diff_q, {TOL_W{1'b0}}} < band_prod;
    if (!in_band)              stable_next = '0;
    else if (stable_q != '1)   stable_next = stable_q + STABLE_W'(1);
    else                       stable_next = stable_q;
    conv_next   = stable_next >= cfg.stable_needed;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign queue_length_o = qlen_oq;
  assign mean_q12_o     = mean_oq;
  assign steps_done_o   = steps_oq;
  assign converged_o    = conv_oq;
  assign run_over_o     = over_oq;

  // Sequencer, run state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      queue_q     <= '0;
      sum_q       <= '0;
      step_q      <= '0;
      stable_q    <= '0;
      ref_q       <= '0;
      last_mean_q <= '0;
      diff_q      <= '0;
      done_q      <= 1'b0;
      conv_q      <= 1'b0;
      sample_q    <= '0;
      out_valid_q <= 1'b0;
      qlen_oq     <= '0;
      mean_oq     <= '0;
      steps_oq    <= '0;
      conv_oq     <= 1'b0;
      over_oq     <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sample_q <= random_sample_i;
            if (restart_i) begin
              queue_q     <= '0;
              sum_q       <= '0;
              step_q      <= '0;
              stable_q    <= '0;
              ref_q       <= '0;
              last_mean_q <= '0;
              done_q      <= 1'b0;
              conv_q      <= 1'b0;
            end
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (done_q) begin
            state_q <= S_OUT;
          end else begin
            queue_q <= q_next;
            sum_q   <= sum_next;
            step_q  <= step_next;
            state_q <= S_INIT;
          end
        end
        S_INIT: state_q <= S_DIV;
        S_DIV: begin
          if (!div_busy && !mul_busy) begin
            state_q <= S_MEAN;
          end
        end
        S_MEAN: begin
          last_mean_q <= mean;
          diff_q      <= diff;
          state_q     <= S_UPD;
        end
        S_UPD: begin
          stable_q <= stable_next;
          if (!in_band) begin
            ref_q <= last_mean_q;
          end
          conv_q  <= conv_next;
          done_q  <= conv_next || (step_q >= cfg.step_limit);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            qlen_oq     <= QLEN_W'(queue_q);
            mean_oq     <= last_mean_q;
            steps_oq    <= step_q;
            conv_oq     <= conv_q;
            over_oq     <= done_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
